### hw/rtl/nsvd_pkg.sv
package nsvd_pkg;

    localparam int SampleWidth = 16;
    localparam int PositionWidth = 32;
    localparam int RefWidth = 24;
    localparam int MinWidth = 17;
    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth = 16;

    localparam logic [CfgIndexWidth-1:0] REG_FALL_FRACTION = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RISE_FRACTION = 8'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ALPHA = 8'd2;
    localparam logic [CfgIndexWidth-1:0] REG_WINDOW_LENGTH = 8'd3;

    localparam logic [7:0] FALL_FRACTION_RESET = 8'd102;
    localparam logic [7:0] RISE_FRACTION_RESET = 8'd154;
    localparam logic [7:0] ALPHA_RESET = 8'd26;
    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd1024;

    localparam logic [MinWidth-1:0] MIN_EMPTY = '1;

    typedef struct packed {
        logic [7:0]  fall_fraction;
        logic [7:0]  rise_fraction;
        logic [7:0]  alpha;
        logic [15:0] window_length;
    } cfg_t;

    typedef struct packed {
        logic                     emit;
        logic [PositionWidth-1:0] null_position;
        logic [SampleWidth-1:0]   null_level;
    } result_t;

endpackage

### hw/rtl/nsvd_core.sv
module nsvd_core
    import nsvd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [SampleWidth-1:0] sample,
    input  cfg_t                   cfg,
    output result_t                result
);

    logic                     low_mode_reg, low_mode_next;
    logic                     ref_valid_reg, ref_valid_next;
    logic [RefWidth-1:0]      ref_reg, ref_next;
    logic [MinWidth-1:0]      min_value_reg, min_value_next;
    logic [PositionWidth-1:0] min_pos_reg, min_pos_next;
    logic [SampleWidth-1:0]   win_max_reg, win_max_next;
    logic [15:0]              win_count_reg, win_count_next;
    logic [PositionWidth-1:0] index_reg;

    logic [31:0]              scaled;
    logic [31:0]              fall_th;
    logic [31:0]              rise_th;
    logic                     fall_hit;
    logic                     rise_hit;
    logic [SampleWidth-1:0]   win_max_now;
    logic                     window_end;
    logic signed [24:0]       diff;
    logic signed [33:0]       prod;
    logic [RefWidth-1:0]      smoothed;

    assign scaled = {sample, 16'h0000};
    assign fall_th = {8'd0, ref_reg} * {24'd0, cfg.fall_fraction};
    assign rise_th = {8'd0, ref_reg} * {24'd0, cfg.rise_fraction};
    assign fall_hit = scaled < fall_th;
    assign rise_hit = scaled >= rise_th;
    assign win_max_now = (sample > win_max_reg) ? sample : win_max_reg;
    assign window_end = win_count_reg == (cfg.window_length - 16'd1);

    // The step towards the window maximum is floored, so an arithmetic shift suffices.
    assign diff = $signed({1'b0, win_max_now, 8'h00}) - $signed({1'b0, ref_reg});
    assign prod = diff * $signed({1'b0, cfg.alpha});
    assign smoothed = ref_reg + prod[31:8];

    always_comb begin
        low_mode_next = low_mode_reg;
        ref_valid_next = ref_valid_reg;
        ref_next = ref_reg;
        min_value_next = min_value_reg;
        min_pos_next = min_pos_reg;
        win_max_next = win_max_now;
        win_count_next = win_count_reg + 16'd1;
        result.emit = 1'b0;
        result.null_position = min_pos_reg;
        result.null_level = min_value_reg[SampleWidth-1:0];

        if (ref_valid_reg) begin
            if (low_mode_reg) begin
                if ({1'b0, sample} <= min_value_reg) begin
                    min_value_next = {1'b0, sample};
                    min_pos_next = index_reg;
                end else if (rise_hit) begin
                    result.emit = 1'b1;
                    low_mode_next = fall_hit;
                    min_value_next = fall_hit ? {1'b0, sample} : MIN_EMPTY;
                    min_pos_next = fall_hit ? index_reg : '0;
                end
            end else if (fall_hit) begin
                low_mode_next = 1'b1;
                min_value_next = {1'b0, sample};
                min_pos_next = index_reg;
            end
        end

        if (window_end) begin
            if (!ref_valid_reg) begin
                ref_next = {win_max_now, 8'h00};
                ref_valid_next = 1'b1;
            end else if (!low_mode_next) begin
                ref_next = smoothed;
            end
            win_max_next = '0;
            win_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mode_reg <= 1'b0;
            ref_valid_reg <= 1'b0;
            ref_reg <= '0;
            min_value_reg <= MIN_EMPTY;
            min_pos_reg <= '0;
            win_max_reg <= '0;
            win_count_reg <= '0;
            index_reg <= '0;
        end else if (step) begin
            low_mode_reg <= low_mode_next;
            ref_valid_reg <= ref_valid_next;
            ref_reg <= ref_next;
            min_value_reg <= min_value_next;
            min_pos_reg <= min_pos_next;
            win_max_reg <= win_max_next;
            win_count_reg <= win_count_next;
            index_reg <= index_reg + 32'd1;
        end
    end

endmodule

### hw/rtl/null_symbol_valley_detector.sv
// Samples wait in the input register; any result word waits in the result register.
// Throughput: one sample word per cycle; the input register and the result register
// let the core step on every cycle in which the result slot is free or being taken.
// Reset: synchronous, active low; clears the valley and reference state, the sample
// index and both valid flags, and restores the register defaults.
module null_symbol_valley_detector
    import nsvd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] sample
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [47:0]              m_tdata,   // [31:0] null_position, [47:32] null_level
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic [SampleWidth-1:0] sample_reg;
    logic                   out_valid_reg;
    logic [47:0]            out_data_reg;
    logic                   fire;
    result_t                result;

    assign fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    nsvd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fall_fraction <= FALL_FRACTION_RESET;
            cfg_reg.rise_fraction <= RISE_FRACTION_RESET;
            cfg_reg.alpha <= ALPHA_RESET;
            cfg_reg.window_length <= WINDOW_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FALL_FRACTION: cfg_reg.fall_fraction <= cfg_data[7:0];
                REG_RISE_FRACTION: cfg_reg.rise_fraction <= cfg_data[7:0];
                REG_ALPHA:         cfg_reg.alpha <= cfg_data[7:0];
                REG_WINDOW_LENGTH: cfg_reg.window_length <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= result.emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result.emit) begin
            out_data_reg <= {result.null_level, result.null_position};
        end
    end

endmodule

### hw/rtl/nsvd_checker.sv
module nsvd_checker
    import nsvd_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [47:0]              m_tdata,
    input logic                     cfg_valid,
    input logic                     cfg_ready
);

    logic m_accept;

    assign m_accept = m_tvalid && m_tready;

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset leaves no result pending and the input side open.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state not cleared by reset");

    // Each sample gives at most one result, so back-to-back results name different samples.
    a_distinct_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept ##1 m_accept |-> m_tdata[31:0] != $past(m_tdata[31:0]))
        else $error("same null position delivered twice");

    // The configuration port never stalls.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind null_symbol_valley_detector nsvd_checker u_nsvd_checker (.*);
